// ----- rtl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and constants for the lru page replacement block
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int unsigned CFG_W      = 4;
    localparam int unsigned FIDX_W     = 3;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned ACT_W      = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic read;
        logic commit;
    } t_lpr_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_addr;
        logic out_busy;
    } t_lpr_sts;

endpackage

// ----- rtl/lpr_ram.sv -----
// ----------------------------------------------------------------------------
// lpr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lpr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpr_ctrl
// sequencer: accept, walk the frames, drain the last read, commit
// ----------------------------------------------------------------------------
module lpr_ctrl import lpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_lpr_sts i_sts,
    output t_lpr_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lpr_dpath.sv -----
// ----------------------------------------------------------------------------
// lpr_dpath
// frame tables, scan compare registers, counters and result register
// ----------------------------------------------------------------------------
module lpr_dpath import lpr_pkg::*; #(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_out_stall,
    input  t_lpr_cmd             i_cmd,
    output t_lpr_sts             o_sts,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_fault_count
);

    localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [CFG_W-1:0]     r_frames_in_use;
    logic [ACT_W-1:0]     w_active;
    logic [FRAMES-1:0]    r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_cmp_en;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [CNT_W-1:0]     r_time;
    logic [CNT_W-1:0]     r_faults;

    logic                 r_hit_found;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;
    logic                 r_min_seen;
    logic [CNT_W-1:0]     r_min_lu;
    logic [IDX_W-1:0]     r_min_idx;
    logic [PAGE_BITS-1:0] r_min_page;

    logic [PAGE_BITS-1:0] w_rd_page;
    logic [CNT_W-1:0]     w_rd_lu;
    logic                 w_cmp_valid;
    logic [IDX_W-1:0]     w_slot;
    logic                 w_evict;
    logic [CNT_W-1:0]     w_faults_next;

    // a count of zero acts as one, above the table size acts as the size
    always_comb begin
        w_active = ACT_W'(r_frames_in_use);
        if (w_active == '0) begin
            w_active = ACT_W'(1);
        end else if (w_active > ACT_W'(FRAMES)) begin
            w_active = ACT_W'(FRAMES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    assign o_sts.last_addr = (ACT_W'(r_addr) == (w_active - ACT_W'(1)));
    assign o_sts.out_busy  = o_out_valid && i_out_stall;

    lpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (w_slot),
        .i_wdata (r_page),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (w_rd_page)
    );

    lpr_ram #(.WIDTH(CNT_W), .DEPTH(FRAMES)) u_lu_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (w_slot),
        .i_wdata (r_time),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (w_rd_lu)
    );

    assign w_cmp_valid = r_valid[r_cmp_idx];

    // address walk, compare each frame in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page       <= i_page_number;
            r_addr       <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_min_seen   <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_addr    <= IDX_W'(r_addr + IDX_W'(1));
                r_cmp_idx <= r_addr;
            end
            if (r_cmp_en) begin
                if (w_cmp_valid && (w_rd_page == r_page) && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                end
                if (!w_cmp_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                // strict less keeps the lowest index on a tie
                if (w_cmp_valid && (!r_min_seen || (w_rd_lu < r_min_lu))) begin
                    r_min_seen <= 1'b1;
                    r_min_lu   <= w_rd_lu;
                    r_min_idx  <= r_cmp_idx;
                    r_min_page <= w_rd_page;
                end
            end
        end
    end

    always_comb begin
        w_evict = 1'b0;
        priority if (r_hit_found) begin
            w_slot = r_hit_idx;
        end else if (r_free_found) begin
            w_slot = r_free_idx;
        end else begin
            w_slot  = r_min_idx;
            w_evict = 1'b1;
        end
    end

    assign w_faults_next = (!r_hit_found && (r_faults != '1))
                         ? CNT_W'(r_faults + CNT_W'(1)) : r_faults;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_time   <= '0;
            r_faults <= '0;
        end else if (i_cmd.commit) begin
            r_valid[w_slot] <= 1'b1;
            r_faults        <= w_faults_next;
            if (r_time != '1) begin
                r_time <= CNT_W'(r_time + CNT_W'(1));
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit           <= r_hit_found;
            o_frame_index   <= FIDX_W'(w_slot);
            o_evicted_valid <= w_evict;
            o_evicted_page  <= w_evict ? r_min_page : '0;
            o_fault_count   <= w_faults_next;
        end
    end

endmodule

// ----- rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative page frame table with least recently used replacement
// ----------------------------------------------------------------------------
// Each input transaction carries one page reference. The block walks the
// active frames one per cycle through a single read port of the page and
// last-use tables, finding a matching page, the lowest free frame and the
// least recently used frame in the same pass. A reference runs through an
// accept state, a read of each active frame (frames_in_use clamped to
// 1..FRAMES), a drain state for the last read to land and a commit state,
// where the result register loads; the walk over the table read port sets
// the length of a reference, and the commit waits while an earlier result
// is still stalled in the output register. The next reference is accepted
// in the cycle after the commit, even while the previous result still
// waits in the output register, so a new reference is not taken before the
// previous one commits. Valid bits are flip-flops cleared at reset, so no
// clearing pass is needed. Write frames_in_use only while the block is
// idle.
// ----------------------------------------------------------------------------
module lru_page_replacement import lpr_pkg::*; #(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // reference input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PAGE_BITS-1:0] i_page_number,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_fault_count
);

    t_lpr_cmd w_cmd;
    t_lpr_sts w_sts;

    // sequencer
    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tables, search registers, counters and result register
    lpr_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_number   (i_page_number),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

`ifndef SYNTHESIS
    // a result is never committed over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !w_sts.out_busy)
        else $error("result committed while output register busy");

    // a commit always shows up as a pending result
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("commit did not raise output valid");

    // an accepted transaction closes the input until its commit
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accept");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit reported with eviction");

    // evicted page reads zero when nothing was replaced
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page nonzero without eviction");
`endif

endmodule
